>>> hdl/habs_pkg.sv
// Package for the health-aware backend selector.
// Holds defaults, field widths, beat layout, modulo constants, mode codes and the sequencer state type.
// No dependencies.
package habs_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ADDRESSES_DEF = 16;
    localparam int POOLS_DEF         = 64;

    // Input field widths
    localparam int POOL_ID_W   = 6;
    localparam int POOL_SIZE_W = 5;
    localparam int MODE_W      = 2;
    localparam int SESSION_W   = 32;
    localparam int MASK_W      = 16;

    // Number of distinct pool_id codes
    localparam int POOL_ID_SPAN = 1 << POOL_ID_W;

    // Output field width
    localparam int INDEX_W = 4;

    // Input beat layout, lowest bit first
    localparam int POOL_ID_LSB   = 0;
    localparam int POOL_SIZE_LSB = POOL_ID_LSB + POOL_ID_W;
    localparam int MODE_LSB      = POOL_SIZE_LSB + POOL_SIZE_W;
    localparam int SESSION_LSB   = MODE_LSB + MODE_W;
    localparam int OK_LSB        = SESSION_LSB + SESSION_W;
    localparam int FADE_LSB      = OK_LSB + MASK_W;
    localparam int LIVE_LSB      = FADE_LSB + MASK_W;
    localparam int FADING_LSB    = LIVE_LSB + MASK_W;
    localparam int S_FIELDS_W    = FADING_LSB + MASK_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((INDEX_W + 7) / 8) * 8;

    // Session modulo: session bits retired per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = SESSION_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Stickiness modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAILOVER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STICKY   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PTR,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

>>> hdl/health_aware_backend_selector.sv
// Health-aware backend selector, top level.
// Depends on habs_pkg and habs_ram (per-pool round-robin pointer table).
//
// Usage:
//   Slave channel s_*: one beat is one request (pool, size, mode, session and
//   four per-address health masks). Master channel m_*: one beat per request
//   carrying the chosen address index. Results leave in request order.
//   Requests are handled one at a time. States from accept to the result
//   being loaded into the output register:
//     pool size 0 or 1                      : FINISH
//     failover                              : SCAN, FINISH
//     round robin (incl. sticky, session 0) : PTR (table read), SCAN, FINISH
//     session-sticky, session nonzero       : MOD (the 4-bit-per-cycle session
//                                             modulo unit), SCAN, FINISH
//   s_tready returns in the same cycle that the result appears in the output
//   register, so a request can be taken while the previous result waits.
//   Reset: aresetn is synchronous, active low. After reset the pointer table
//   is cleared one entry per cycle, all POOLS entries, with s_tready held low.
//   Stall: a held result blocks only the next result; the following request
//   is still accepted and processed up to its output load.
module health_aware_backend_selector #(
    parameter int MAX_ADDRESSES = habs_pkg::MAX_ADDRESSES_DEF,
    parameter int POOLS         = habs_pkg::POOLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request beat, lowest bit up: pool_id[6], pool_size[5], affinity_mode[2],
    // session[32], fail_ok_mask[16], fail_fade_mask[16], live_mask[16],
    // fading_mask[16], zero fill[3]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [habs_pkg::S_TDATA_W-1:0] s_tdata,
    // Result beat, lowest bit up: chosen_index[4], zero fill[4]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [habs_pkg::M_TDATA_W-1:0] m_tdata
);
    import habs_pkg::*;

    localparam int IDX_W = $clog2(MAX_ADDRESSES);
    localparam int SZ_W  = $clog2(MAX_ADDRESSES + 1);
    localparam int PA_W  = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int LANES = (MAX_ADDRESSES < MASK_W) ? MAX_ADDRESSES : MASK_W;

    // Constant map from pool_id to table address
    logic [PA_W-1:0] pool_map [POOL_ID_SPAN];

    for (genvar g = 0; g < POOL_ID_SPAN; g++) begin : g_pool_map
        assign pool_map[g] = PA_W'(g % POOLS);
    end

    // Control registers
    state_t                 state_reg, state_next;
    logic [PA_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg, mod_cnt_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload registers
    logic [PA_W-1:0]        pool_reg, pool_next;
    logic [SZ_W-1:0]        size_reg, size_next;
    logic [SESSION_W-1:0]   sess_reg, sess_next;
    logic [MASK_W-1:0]      ok_reg, ok_next;
    logic [MASK_W-1:0]      fade_reg, fade_next;
    logic [MASK_W-1:0]      live_reg, live_next;
    logic [MASK_W-1:0]      fading_reg, fading_next;
    logic [SZ_W:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]       start_reg, start_next;
    logic                   fade_first_reg, fade_first_next;
    logic                   fade_rest_reg, fade_rest_next;
    logic                   rr_reg, rr_next;
    logic [IDX_W-1:0]       result_reg, result_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Pointer table port signals
    logic                   ram_wr_en;
    logic [PA_W-1:0]        ram_wr_addr;
    logic [IDX_W-1:0]       ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_data;

    // Request field views
    logic [POOL_ID_W-1:0]   in_pool;
    logic [POOL_SIZE_W-1:0] in_size_raw;
    logic [MODE_W-1:0]      in_mode;
    logic [SESSION_W-1:0]   in_session;
    logic [SZ_W-1:0]        in_size;
    logic                   accept;
    logic                   out_free;

    // Scan and modulo temporaries
    logic [MASK_W-1:0]      use_hi, use_lo;
    logic                   found_hi, found_lo;
    logic [IDX_W-1:0]       idx_hi, idx_lo, scan_idx;
    logic [SZ_W:0]          rem_tmp;
    logic [SZ_W-1:0]        ptr_inc;

    assign in_pool     = s_tdata[POOL_ID_LSB +: POOL_ID_W];
    assign in_size_raw = s_tdata[POOL_SIZE_LSB +: POOL_SIZE_W];
    assign in_mode     = s_tdata[MODE_LSB +: MODE_W];
    assign in_session  = s_tdata[SESSION_LSB +: SESSION_W];

    // Saturate pool size to the address limit
    always_comb begin
        if (32'(in_size_raw) > 32'(MAX_ADDRESSES)) begin
            in_size = SZ_W'(MAX_ADDRESSES);
        end else begin
            in_size = SZ_W'(in_size_raw);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Usable addresses, split into the part at or after start and the wrap part
    always_comb begin
        use_hi = '0;
        use_lo = '0;
        for (int i = 0; i < LANES; i++) begin
            logic allow;
            logic good;
            allow = (IDX_W'(i) == start_reg) ? fade_first_reg : fade_rest_reg;
            good  = (ok_reg[i] || (allow && fade_reg[i])) && live_reg[i]
                    && (allow || !fading_reg[i]) && (SZ_W'(i) < size_reg);
            if (IDX_W'(i) >= start_reg) begin
                use_hi[i] = good;
            end else begin
                use_lo[i] = good;
            end
        end
    end

    // Lowest set bit of each part
    always_comb begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        idx_hi   = '0;
        idx_lo   = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (use_hi[i]) begin
                found_hi = 1'b1;
                idx_hi   = IDX_W'(i);
            end
            if (use_lo[i]) begin
                found_lo = 1'b1;
                idx_lo   = IDX_W'(i);
            end
        end
        priority if (found_hi) begin
            scan_idx = idx_hi;
        end else if (found_lo) begin
            scan_idx = idx_lo;
        end else begin
            scan_idx = start_reg;
        end
    end

    // Retire MOD_BITS session bits into the remainder
    always_comb begin
        rem_tmp = rem_reg;
        for (int b = 0; b < MOD_BITS; b++) begin
            rem_tmp = {rem_tmp[SZ_W-1:0], sess_reg[SESSION_W-1-b]};
            if (rem_tmp >= {1'b0, size_reg}) begin
                rem_tmp = rem_tmp - {1'b0, size_reg};
            end
        end
    end

    // Pointer one past the result, wrapped to the pool size
    always_comb begin
        ptr_inc = SZ_W'(result_reg) + SZ_W'(1);
        if (ptr_inc >= size_reg) begin
            ptr_inc = '0;
        end
    end

    // Sequencer: next state and datapath
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mod_cnt_next    = mod_cnt_reg;
        m_valid_next    = m_valid_reg;
        pool_next       = pool_reg;
        size_next       = size_reg;
        sess_next       = sess_reg;
        ok_next         = ok_reg;
        fade_next       = fade_reg;
        live_next       = live_reg;
        fading_next     = fading_reg;
        rem_next        = rem_reg;
        start_next      = start_reg;
        fade_first_next = fade_first_reg;
        fade_rest_next  = fade_rest_reg;
        rr_next         = rr_reg;
        result_next     = result_reg;
        m_data_next     = m_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pool_reg;
        ram_wr_data     = IDX_W'(ptr_inc);
        ram_rd_en       = accept;

        // Drop the held result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + PA_W'(1);
                if (clr_cnt_reg == PA_W'(POOLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    pool_next   = pool_map[in_pool];
                    size_next   = in_size;
                    sess_next   = in_session;
                    ok_next     = s_tdata[OK_LSB +: MASK_W];
                    fade_next   = s_tdata[FADE_LSB +: MASK_W];
                    live_next   = s_tdata[LIVE_LSB +: MASK_W];
                    fading_next = s_tdata[FADING_LSB +: MASK_W];
                    rr_next     = 1'b0;
                    start_next  = '0;
                    rem_next    = '0;
                    mod_cnt_next = '0;
                    priority if (in_size <= SZ_W'(1)) begin
                        result_next = '0;
                        state_next  = ST_FINISH;
                    end else if (in_mode == MODE_FAILOVER) begin
                        fade_first_next = 1'b1;
                        fade_rest_next  = 1'b1;
                        state_next      = ST_SCAN;
                    end else if (in_mode == MODE_STICKY && in_session != '0) begin
                        fade_first_next = 1'b1;
                        fade_rest_next  = 1'b0;
                        state_next      = ST_MOD;
                    end else begin
                        fade_first_next = (in_mode == MODE_NONE);
                        fade_rest_next  = (in_mode == MODE_NONE);
                        rr_next         = 1'b1;
                        state_next      = ST_PTR;
                    end
                end
            end
            ST_MOD: begin
                rem_next     = rem_tmp;
                sess_next    = sess_reg << MOD_BITS;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1)) begin
                    start_next = IDX_W'(rem_tmp);
                    state_next = ST_SCAN;
                end
            end
            ST_PTR: begin
                // Restart at zero when the pool shrank under the pointer
                if (SZ_W'(ram_rd_data) >= size_reg) begin
                    start_next = '0;
                end else begin
                    start_next = ram_rd_data;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                result_next = scan_idx;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // Load the output and, for round robin, write back the pointer together
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'(INDEX_W'(result_reg));
                    ram_wr_en    = rr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            mod_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            mod_cnt_reg <= mod_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        pool_reg       <= pool_next;
        size_reg       <= size_next;
        sess_reg       <= sess_next;
        ok_reg         <= ok_next;
        fade_reg       <= fade_next;
        live_reg       <= live_next;
        fading_reg     <= fading_next;
        rem_reg        <= rem_next;
        start_reg      <= start_next;
        fade_first_reg <= fade_first_next;
        fade_rest_reg  <= fade_rest_next;
        rr_reg         <= rr_next;
        result_reg     <= result_next;
        m_data_reg     <= m_data_next;
    end

    // Round-robin pointer table
    habs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOLS)
    ) u_ptr_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (pool_map[in_pool]),
        .rd_data (ram_rd_data)
    );

`ifndef ASSERT_OFF
    // No request is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("request accepted during table clear");

    // Table writes only come from the clear sweep or a pointer write-back
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == ST_CLEAR || (state_reg == ST_FINISH && rr_reg)))
        else $error("unexpected pointer table write");

    // The modulo unit hands over to the scan after its last step
    a_mod_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD && mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
        |=> state_reg == ST_SCAN)
        else $error("modulo sequence did not end in scan");

    // The scan start lies inside the pool
    a_start_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> SZ_W'(start_reg) < size_reg)
        else $error("scan start outside pool");

    // A chosen index lies inside the pool
    a_result_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && size_reg != '0) |-> SZ_W'(result_reg) < size_reg)
        else $error("chosen index outside pool");
`endif

endmodule

>>> hdl/habs_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module habs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
